[sv/mrc_pkg.sv]
// Shared types and constants for the mixed-radix index counter.
`timescale 1ns / 1ps

package mrc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BEGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 3'd5;

  // Fixed field widths
  localparam int RANGE_W = 32;  // range_begin, range_end, remaining count
  localparam int FIELD_W = 16;  // step and digit fields
  localparam int MAX_DIMS = 4;

  // Divider dividend / quotient width
  localparam int DIV_W = 32;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BAD_BEGIN = 2'd1,
    ERR_BAD_STEP  = 2'd2,
    ERR_DIGIT_OVF = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START_DIM,
    S_START_DIV,
    S_CARRY,
    S_REMAIN,
    S_ROOM,
    S_ROWS_DIV,
    S_OUTPUT
  } state_t;

endpackage

[sv/mixed_radix_index_counter.sv]
// Mixed-radix index counter: digit loading, carry walk and next-step planning.
// A step item walks the carry through the digits, then works out the remaining count and
//   the room for the next step, with an iterative divide for the row count when the inner
//   step spans a whole row; a start item first splits range_begin, one divide per nonzero size.
// One item at a time; the shared 32-bit iterative divider serves both kinds of divide.
// A result waits in the output register while the next item is accepted.
// Reset (synchronous, active low): digits and position 0, sizes 1, range 0, no result.
`timescale 1ns / 1ps

module mixed_radix_index_counter #(
  parameter int NUM_DIMS      = 4,
  parameter int SIZE_BITS     = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_wr_en,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // step_inner[15:0], step_outer[31:16]
  input  logic [0:0]                      in_tuser,   // action[0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [127:0]                    out_tdata,  // index_0..index_3 [63:0],
                                                      // position [95:64],
                                                      // next_step_inner [111:96],
                                                      // next_step_outer [127:112]
  output logic                            out_tlast,  // done_res
  output logic [1:0]                      out_tuser   // error[1:0]
);

  localparam int DIG_W = (SIZE_BITS < mrc_pkg::FIELD_W) ? SIZE_BITS : mrc_pkg::FIELD_W;
  localparam int CW    = (POSITION_BITS > mrc_pkg::RANGE_W) ? POSITION_BITS : mrc_pkg::RANGE_W;
  localparam int IDX_W = $clog2(NUM_DIMS);
  localparam int CNT_W = $clog2(NUM_DIMS + 1);
  localparam int FW    = mrc_pkg::FIELD_W;
  localparam int RW    = mrc_pkg::RANGE_W;

  localparam logic [CW-1:0] POS_MAX  = CW'((65'd1 << POSITION_BITS) - 65'd1);
  localparam logic [CW-1:0] OUT_MAX  = CW'({RW{1'b1}});

  // Configuration registers
  logic [DIG_W-1:0] size_r [NUM_DIMS];
  logic [RW-1:0]    begin_r;
  logic [RW-1:0]    end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DIMS; d++) size_r[d] <= DIG_W'(1);
      begin_r <= '0;
      end_r   <= '0;
    end else if (cfg_wr_en) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        if (cfg_index == mrc_pkg::CFG_DIM_SIZE_0 + mrc_pkg::CFG_IDX_W'(d))
          size_r[d] <= cfg_data[DIG_W-1:0];
      end
      if (cfg_index == mrc_pkg::CFG_RANGE_BEGIN) begin_r <= cfg_data[RW-1:0];
      if (cfg_index == mrc_pkg::CFG_RANGE_END)   end_r   <= cfg_data[RW-1:0];
    end
  end

  // Sequencer and datapath registers
  mrc_pkg::state_t          state_r, state_nxt;
  logic [DIG_W-1:0]         digits_r [NUM_DIMS];
  logic [DIG_W-1:0]         digits_nxt [NUM_DIMS];
  logic [DIG_W-1:0]         wd_r [NUM_DIMS];    // working digits
  logic [DIG_W-1:0]         wd_nxt [NUM_DIMS];
  logic [POSITION_BITS-1:0] lp_r, lp_nxt;
  logic [CNT_W-1:0]         i_r, i_nxt;
  logic [FW-1:0]            carry_r, carry_nxt;
  logic [RW-1:0]            rem_r, rem_nxt;       // start residue, then remaining count
  logic [RW-1:0]            prod_r, prod_nxt;
  mrc_pkg::err_t            err_r, err_nxt;
  logic [DIG_W-1:0]         st0_r, st0_nxt;
  logic [DIG_W-1:0]         st1_r, st1_nxt;

  // Output register
  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic         out_last_r;
  logic [1:0]   out_user_r;
  logic         out_load;

  // Divider hookup
  logic                      div_start;
  logic [mrc_pkg::DIV_W-1:0] div_dividend;
  logic [DIG_W-1:0]          div_divisor;
  logic                      div_done;
  logic [mrc_pkg::DIV_W-1:0] div_quot;
  logic [DIG_W-1:0]          div_rem;

  mrc_divider #(
    .DVS_W (DIG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Input fields
  logic [FW-1:0]    in_si;
  logic [FW-1:0]    in_so;
  mrc_pkg::action_t in_act;
  logic             in_xfer;

  assign in_si     = in_tdata[15:0];
  assign in_so     = in_tdata[31:16];
  assign in_act    = mrc_pkg::action_t'(in_tuser[0]);
  assign in_tready = (state_r == mrc_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // Helpers shared by the states
  logic [IDX_W-1:0] i_idx;
  logic [CW-1:0]    lp_ext;
  logic [CW:0]      sum;
  logic [FW:0]      cv;
  logic [FW:0]      cv_sub;
  logic [FW:0]      csz;
  logic [DIG_W-1:0] room0;
  logic [DIG_W-1:0] room1;
  logic [DIG_W-1:0] st0_c;
  logic [CW-1:0]    end_ext;
  logic [CW-1:0]    begin_ext;

  assign i_idx     = i_r[IDX_W-1:0];
  assign lp_ext    = CW'(lp_r);
  assign end_ext   = CW'(end_r);
  assign begin_ext = CW'(begin_r);
  assign sum       = (CW+1)'(lp_ext) + (CW+1)'(prod_r);
  assign csz       = (FW+1)'(size_r[i_idx]);
  assign cv        = (FW+1)'(wd_r[i_idx]) + (FW+1)'(carry_r);
  assign cv_sub    = cv - csz;
  assign room0     = (digits_r[0] < size_r[0]) ? size_r[0] - digits_r[0] : '0;
  assign room1     = (digits_r[1] < size_r[1]) ? size_r[1] - digits_r[1] : '0;
  assign st0_c     = (RW'(room0) < rem_r) ? room0 : DIG_W'(rem_r);

  // Next state and datapath updates
  always_comb begin
    state_nxt    = state_r;
    digits_nxt   = digits_r;
    wd_nxt       = wd_r;
    lp_nxt       = lp_r;
    i_nxt        = i_r;
    carry_nxt    = carry_r;
    rem_nxt      = rem_r;
    prod_nxt     = prod_r;
    err_nxt      = err_r;
    st0_nxt      = st0_r;
    st1_nxt      = st1_r;
    div_start    = 1'b0;
    div_dividend = rem_r;
    div_divisor  = (state_r == mrc_pkg::S_ROOM) ? size_r[0] : size_r[i_idx];
    out_load     = 1'b0;

    unique case (state_r)
      mrc_pkg::S_IDLE: begin
        if (in_xfer) begin
          prod_nxt = RW'(in_si) * RW'(in_so);
          err_nxt  = mrc_pkg::ERR_NONE;
          i_nxt    = '0;
          if (in_act == mrc_pkg::ACT_START) begin
            rem_nxt = begin_r;
            for (int d = 0; d < NUM_DIMS; d++) wd_nxt[d] = '0;
            state_nxt = mrc_pkg::S_START_DIM;
          end else begin
            wd_nxt    = digits_r;
            carry_nxt = in_si;
            state_nxt = mrc_pkg::S_CARRY;
            if (in_so != FW'(1)) begin
              // multi-row step needs a whole row from digit 0
              if (in_si != FW'(size_r[0]) || digits_r[0] != '0) begin
                err_nxt   = mrc_pkg::ERR_BAD_STEP;
                state_nxt = mrc_pkg::S_REMAIN;
              end else begin
                i_nxt     = CNT_W'(1);
                carry_nxt = in_so;
              end
            end
          end
        end
      end

      // split range_begin one dimension at a time
      mrc_pkg::S_START_DIM: begin
        if (i_r == CNT_W'(NUM_DIMS)) begin
          err_nxt    = (rem_r != '0) ? mrc_pkg::ERR_BAD_BEGIN : mrc_pkg::ERR_NONE;
          digits_nxt = wd_r;
          lp_nxt     = (begin_ext > POS_MAX) ? POSITION_BITS'(POS_MAX)
                                             : POSITION_BITS'(begin_ext);
          state_nxt  = mrc_pkg::S_REMAIN;
        end else if (size_r[i_idx] == '0) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          div_start = 1'b1;
          state_nxt = mrc_pkg::S_START_DIV;
        end
      end

      mrc_pkg::S_START_DIV: begin
        if (div_done) begin
          wd_nxt[i_idx] = div_rem;
          rem_nxt       = div_quot;
          i_nxt         = i_r + CNT_W'(1);
          state_nxt     = mrc_pkg::S_START_DIM;
        end
      end

      // ripple the carry one digit per cycle
      mrc_pkg::S_CARRY: begin
        if (i_r != CNT_W'(NUM_DIMS) && carry_r != '0) begin
          if (cv >= csz) begin
            if (cv_sub >= csz) begin
              err_nxt   = mrc_pkg::ERR_DIGIT_OVF;
              state_nxt = mrc_pkg::S_REMAIN;
            end else begin
              wd_nxt[i_idx] = DIG_W'(cv_sub);
              carry_nxt     = FW'(1);
              i_nxt         = i_r + CNT_W'(1);
            end
          end else begin
            wd_nxt[i_idx] = DIG_W'(cv);
            carry_nxt     = '0;
            i_nxt         = i_r + CNT_W'(1);
          end
        end else begin
          digits_nxt = wd_r;
          lp_nxt     = (sum > (CW+1)'(POS_MAX)) ? POSITION_BITS'(POS_MAX)
                                                : POSITION_BITS'(sum);
          state_nxt  = mrc_pkg::S_REMAIN;
        end
      end

      // remaining count, clamped at zero
      mrc_pkg::S_REMAIN: begin
        rem_nxt   = (end_ext > lp_ext) ? RW'(end_ext - lp_ext) : '0;
        state_nxt = mrc_pkg::S_ROOM;
      end

      mrc_pkg::S_ROOM: begin
        st0_nxt = st0_c;
        st1_nxt = DIG_W'(1);
        state_nxt = mrc_pkg::S_OUTPUT;
        if (st0_c == size_r[0]) begin
          if (size_r[0] == '0) begin
            st1_nxt = '0;
          end else begin
            div_start = 1'b1;
            state_nxt = mrc_pkg::S_ROWS_DIV;
          end
        end
      end

      mrc_pkg::S_ROWS_DIV: begin
        if (div_done) begin
          st1_nxt   = (RW'(room1) < div_quot) ? room1 : DIG_W'(div_quot);
          state_nxt = mrc_pkg::S_OUTPUT;
        end
      end

      mrc_pkg::S_OUTPUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = mrc_pkg::S_IDLE;
        end
      end

      default: state_nxt = mrc_pkg::S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrc_pkg::S_IDLE;
      for (int d = 0; d < NUM_DIMS; d++) digits_r[d] <= '0;
      lp_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      digits_r <= digits_nxt;
      lp_r     <= lp_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    wd_r    <= wd_nxt;
    i_r     <= i_nxt;
    carry_r <= carry_nxt;
    rem_r   <= rem_nxt;
    prod_r  <= prod_nxt;
    err_r   <= err_nxt;
    st0_r   <= st0_nxt;
    st1_r   <= st1_nxt;
  end

  // Result assembly
  logic [127:0] res_data;
  logic [RW-1:0] pos_out;

  assign pos_out = (lp_ext > OUT_MAX) ? {RW{1'b1}} : RW'(lp_ext);

  always_comb begin
    res_data = '0;
    for (int d = 0; d < NUM_DIMS; d++)
      res_data[d*FW +: FW] = FW'(digits_r[d]);
    res_data[95:64]   = pos_out;
    res_data[111:96]  = FW'(st0_r);
    res_data[127:112] = FW'(st1_r);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_data;
      out_last_r <= (lp_ext >= end_ext);
      out_user_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

[sv/mrc_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mrc_divider #(
  parameter int DVS_W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mrc_pkg::DIV_W-1:0]     dividend,
  input  logic [DVS_W-1:0]              divisor,
  output logic                          done,
  output logic [mrc_pkg::DIV_W-1:0]     quotient,
  output logic [DVS_W-1:0]              remainder
);

  localparam int CNT_W = $clog2(mrc_pkg::DIV_W);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [mrc_pkg::DIV_W-1:0]  acc_r;   // dividend bits out at the top, quotient bits in below
  logic [DVS_W-1:0]           rem_r;
  logic [DVS_W-1:0]           dvs_r;

  logic [DVS_W:0]             trial;
  logic [DVS_W-1:0]           rem_nxt;
  logic                       q_bit;

  // One shift-subtract step
  always_comb begin
    trial = {rem_r, acc_r[mrc_pkg::DIV_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      q_bit   = 1'b1;
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      q_bit   = 1'b0;
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(mrc_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[mrc_pkg::DIV_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = acc_r;
  assign remainder = rem_r;

endmodule

[bench/index_walk_checker.sv]
// Checker for the mixed-radix index counter: mirrors config, predicts each result, compares.
`timescale 1ns / 1ps

module index_walk_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // step_inner[15:0], step_outer[31:16]
  input  logic [0:0]                        in_tuser,   // action[0]
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [127:0]                      out_tdata,  // index_0..3, position, next steps
  input  logic                              out_tlast,  // done_res
  input  logic [1:0]                        out_tuser,  // error[1:0]
  output int                                fail_count,
  output int                                pending_results,
  output int                                n_results,
  output int                                n_bad_begin,
  output int                                n_bad_step,
  output int                                n_digit_ovf
);
  import mrc_pkg::*;

  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [3:0][15:0] digit;
    logic [31:0]      position;
    logic             done;
    logic [15:0]      next_inner;
    logic [15:0]      next_outer;
    err_t             err;
  } walk_result_t;

  // mirrored registers
  logic [15:0] radix [4];
  logic [31:0] walk_first;
  logic [31:0] walk_limit;
  // mirrored counter state
  logic [15:0] digit_q [4];
  logic [31:0] walk_pos;

  walk_result_t predicted_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    n_results       = 0;
    n_bad_begin     = 0;
    n_bad_step      = 0;
    n_digit_ovf     = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS)
      $display("MISMATCH at %0t ns, result %0d: %s", $time, n_results, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Applies one item to the mirrored counter and returns the result it should produce.
  function automatic walk_result_t apply_walk_item(input action_t act,
                                                   input logic [15:0] step_in,
                                                   input logic [15:0] step_rows);
    logic [63:0]  nd [4];
    logic [63:0]  rem;
    logic [63:0]  carry;
    logic [63:0]  v;
    logic [63:0]  sum;
    logic [63:0]  remain;
    logic [63:0]  room0;
    logic [63:0]  room1;
    logic [63:0]  st0;
    logic [63:0]  st1;
    logic [63:0]  rows;
    err_t         err;
    int           i;
    walk_result_t r;

    err = ERR_NONE;
    for (i = 0; i < 4; i++)
      nd[i] = digit_q[i];

    if (act == ACT_START) begin
      // split the begin position digit by digit; zero sizes are skipped
      rem = walk_first;
      for (i = 0; i < 4; i++) begin
        nd[i] = 0;
        if (radix[i] != 0) begin
          nd[i] = rem % radix[i];
          rem   = rem / radix[i];
        end
      end
      if (rem != 0)
        err = ERR_BAD_BEGIN;
      for (i = 0; i < 4; i++)
        digit_q[i] = nd[i][15:0];
      walk_pos = walk_first;
    end else begin
      carry = step_in;
      i = 0;
      // a row step must start at digit 0 and span exactly one inner row
      if (step_rows != 16'd1) begin
        if (step_in != radix[0] || digit_q[0] != 16'd0)
          err = ERR_BAD_STEP;
        i = 1;
        carry = step_rows;
      end
      while (err == ERR_NONE && i < 4 && carry != 0) begin
        v = nd[i] + carry;
        if (v >= radix[i]) begin
          carry = 1;
          v = v - radix[i];
          if (v >= radix[i])
            err = ERR_DIGIT_OVF;
        end else begin
          carry = 0;
        end
        nd[i] = v;
        i++;
      end
      // carry out of the top digit is dropped; rejected steps change nothing
      if (err == ERR_NONE) begin
        for (i = 0; i < 4; i++)
          digit_q[i] = nd[i][15:0];
        sum = 64'(step_in) * 64'(step_rows);
        sum = sum + walk_pos;
        walk_pos = (sum > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
    end

    // largest next 2-D step from the current point
    remain = (walk_limit > walk_pos) ? 64'(walk_limit) - 64'(walk_pos) : 64'd0;
    room0  = (digit_q[0] < radix[0]) ? 64'(radix[0]) - 64'(digit_q[0]) : 64'd0;
    room1  = (digit_q[1] < radix[1]) ? 64'(radix[1]) - 64'(digit_q[1]) : 64'd0;
    st0    = (room0 < remain) ? room0 : remain;
    st1    = 1;
    if (st0 == 64'(radix[0])) begin
      if (radix[0] == 0) begin
        st1 = 0;
      end else begin
        rows = remain / radix[0];
        st1  = (room1 < rows) ? room1 : rows;
      end
    end

    for (i = 0; i < 4; i++)
      r.digit[i] = digit_q[i];
    r.position   = walk_pos;
    r.done       = (walk_pos >= walk_limit);
    r.next_inner = st0[15:0];
    r.next_outer = st1[15:0];
    r.err        = err;
    return r;
  endfunction

  // Watch all three ports at each edge
  always @(posedge clk) begin : watch
    walk_result_t want;
    int           d;
    if (!rst_n) begin
      for (d = 0; d < 4; d++) begin
        radix[d]   = 16'd1;
        digit_q[d] = 16'd0;
      end
      walk_first = '0;
      walk_limit = '0;
      walk_pos   = '0;
      predicted_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_RANGE_BEGIN)
          walk_first = cfg_data;
        else if (cfg_index == CFG_RANGE_END)
          walk_limit = cfg_data;
        else if (cfg_index < CFG_DIM_SIZE_0 + 3'(MAX_DIMS))
          radix[cfg_index - CFG_DIM_SIZE_0] = cfg_data[15:0];
      end

      // result transfer: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result transfer with no prediction waiting");
        end else begin
          want = predicted_results.pop_front();
          for (d = 0; d < 4; d++)
            check_field($sformatf("index_%0d", d), out_tdata[16*d +: 16], want.digit[d]);
          check_field("position", out_tdata[95:64], want.position);
          check_field("next_step_inner", out_tdata[111:96], want.next_inner);
          check_field("next_step_outer", out_tdata[127:112], want.next_outer);
          check_field("done_res", out_tlast, want.done);
          check_field("error", out_tuser, want.err);
          case (want.err)
            ERR_BAD_BEGIN: n_bad_begin++;
            ERR_BAD_STEP:  n_bad_step++;
            ERR_DIGIT_OVF: n_digit_ovf++;
            default: ;
          endcase
        end
        n_results++;
      end

      // input transfer: predict its result
      if (in_tvalid && in_tready)
        predicted_results.push_back(apply_walk_item(action_t'(in_tuser[0]),
                                                    in_tdata[15:0], in_tdata[31:16]));
    end
    pending_results = predicted_results.size();
  end

endmodule

[bench/tb_top.sv]
// Top of the mixed-radix index counter bench: clock, reset, stimulus, flow control, verdict.
`timescale 1ns / 1ps

module tb_top;
  import mrc_pkg::*;

  localparam int CYCLE_LIMIT      = 4_000_000;
  localparam int PHASE_ITEMS      = 50;
  localparam int RANDOM_PHASES    = 39;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES     = 200;   // longer than a four-digit start

  typedef enum int {
    WALK_INNER,
    WALK_ROWS,
    WALK_NOISE
  } walk_style_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata  = '0;   // step_inner[15:0], step_outer[31:16]
  logic [0:0]            in_tuser  = '0;   // action[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [127:0]          out_tdata;        // index_0..3, position, next steps
  logic                  out_tlast;        // done_res
  logic [1:0]            out_tuser;        // error[1:0]

  int fail_count;
  int pending_results;
  int n_results;
  int n_bad_begin;
  int n_bad_step;
  int n_digit_ovf;
  int n_items     = 0;
  int n_configs   = 0;
  int cycle_count = 0;

  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit long_hold_req = 1'b0;

  // register values of the current phase
  logic [15:0] radix [4];
  logic [31:0] walk_first;
  logic [31:0] walk_limit;

  mixed_radix_index_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  index_walk_checker walk_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .n_results       (n_results),
    .n_bad_begin     (n_bad_begin),
    .n_bad_step      (n_bad_step),
    .n_digit_ovf     (n_digit_ovf)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly no gap, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 20);
    else
      return $urandom_range(40, 150);
  endfunction

  // Result side flow control, including the long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One input transfer, then a random gap
  task automatic send_item(input action_t act, input logic [15:0] step_in,
                           input logic [15:0] step_rows);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {step_rows, step_in};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every predicted result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all six registers once the block is idle
  task automatic configure(input logic [15:0] s0, input logic [15:0] s1,
                           input logic [15:0] s2, input logic [15:0] s3,
                           input logic [31:0] first, input logic [31:0] limit);
    int d;
    wait_idle();
    radix[0]   = s0;
    radix[1]   = s1;
    radix[2]   = s2;
    radix[3]   = s3;
    walk_first = first;
    walk_limit = limit;
    for (d = 0; d < MAX_DIMS; d++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_DIM_SIZE_0 + 3'(d);
      cfg_data  <= 32'(radix[d]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_RANGE_BEGIN;
    cfg_data  <= walk_first;
    @(posedge clk);
    cfg_index <= CFG_RANGE_END;
    cfg_data  <= walk_limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_configs++;
  endtask

  // Random sizes (mostly small so carries reach the top digit) and a walk range
  task automatic pick_random_walk(input walk_style_t style);
    logic [15:0] s [4];
    logic [63:0] span;
    logic [63:0] lim;
    logic [31:0] first;
    logic [31:0] limit;
    int          d;
    int          r;
    span = 1;
    for (d = 0; d < 4; d++) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        s[d] = 16'd0;
      else if (r < 7)
        s[d] = 16'hFFFF;
      else if (r < 10)
        s[d] = 16'($urandom);
      else if (r < 18)
        s[d] = 16'd1;
      else
        s[d] = 16'($urandom_range(2, 6));
      if (s[d] != 0)
        span = span * s[d];
    end
    if (span > 64'h0000_0000_FFFF_FFFF)
      span = 64'h0000_0001_0000_0000;
    r = $urandom_range(0, 99);
    if (r < 75)
      first = $urandom_range(0, 32'(span - 1));
    else
      first = $urandom;
    // row walks need digit 0 at zero to take row steps
    if (style == WALK_ROWS && s[0] != 0)
      first = first - first % s[0];
    r = $urandom_range(0, 99);
    if (r < 60) begin
      lim   = 64'(first) + $urandom_range(0, 600);
      limit = (lim > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0];
    end else if (r < 80) begin
      limit = $urandom;
    end else if (r < 90) begin
      limit = first;
    end else if (r < 95) begin
      limit = 32'd0;
    end else begin
      limit = 32'hFFFF_FFFF;
    end
    configure(s[0], s[1], s[2], s[3], first, limit);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    walk_style_t style;
    int          p;
    int          k;
    int          r;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: unit sizes, every step carries off the top digit
    send_item(ACT_START, 16'd0, 16'd1);
    send_item(ACT_STEP, 16'd1, 16'd1);

    // 4x3x5x2 walk: plain steps, row steps, rejected steps, overflow
    configure(16'd4, 16'd3, 16'd5, 16'd2, 32'd7, 32'd100);
    send_item(ACT_START, 16'd0, 16'd1);
    send_item(ACT_STEP, 16'd1, 16'd1);
    send_item(ACT_STEP, 16'd3, 16'd1);
    send_item(ACT_STEP, 16'd4, 16'd2);          // row step off digit 0: rejected
    send_item(ACT_STEP, 16'd1, 16'd1);
    send_item(ACT_STEP, 16'd4, 16'd2);          // two whole rows
    send_item(ACT_STEP, 16'd4, 16'd0);          // zero rows
    send_item(ACT_STEP, 16'hFFFF, 16'd1);       // inner digit overflow
    send_item(ACT_STEP, 16'd0, 16'd1);
    send_item(ACT_STEP, 16'd0, 16'd0);          // row step with wrong inner size
    send_item(ACT_STEP, 16'hFFFF, 16'hFFFF);
    send_item(ACT_STEP, 16'd4, 16'hFFFF);       // overflow in the row digit

    // widest sizes, position saturates
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_START, 16'hFFFF, 16'hFFFF);
    send_item(ACT_STEP, 16'hFFFF, 16'hFFFF);
    send_item(ACT_STEP, 16'hFFFF, 16'd1);

    // zero sizes: skipped on start, residue left over, any carry overflows
    configure(16'd0, 16'd3, 16'd0, 16'd1, 32'hFFFF_FFFF, 32'd5);
    send_item(ACT_START, 16'd0, 16'd1);
    send_item(ACT_STEP, 16'd1, 16'd1);
    send_item(ACT_STEP, 16'd0, 16'd1);

    // binary digits: carry out of the top digit wraps
    configure(16'd2, 16'd2, 16'd2, 16'd2, 32'd13, 32'd0);
    send_item(ACT_START, 16'd0, 16'd1);
    send_item(ACT_STEP, 16'd1, 16'd1);
    send_item(ACT_STEP, 16'd2, 16'd1);

    // shrink the sizes after a start so digits sit above their size
    configure(16'd4, 16'd3, 16'd5, 16'd2, 32'd119, 32'd200);
    send_item(ACT_START, 16'd0, 16'd1);
    configure(16'd2, 16'd2, 16'd2, 16'd2, 32'd0, 32'd200);
    send_item(ACT_STEP, 16'd0, 16'd1);
    send_item(ACT_STEP, 16'd1, 16'd1);

    // random walks, one configuration per phase
    for (p = 0; p < RANDOM_PHASES; p++) begin
      r = $urandom_range(0, 99);
      style = (r < 40) ? WALK_INNER : (r < 80) ? WALK_ROWS : WALK_NOISE;
      pick_random_walk(style);
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      // result side holds off while items keep coming, so the block backs up
      if (p == 2)
        long_hold_req = 1'b1;
      send_item(ACT_START, 16'($urandom), 16'($urandom));
      for (k = 1; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (style == WALK_NOISE || r < 10)
          send_item(action_t'($urandom_range(0, 1)), 16'($urandom),
                    ($urandom_range(0, 1) == 0) ? 16'd1 : 16'($urandom));
        else if (r < 15)
          send_item(ACT_START, 16'($urandom), 16'($urandom));
        else if (style == WALK_INNER)
          send_item(ACT_STEP, 16'($urandom_range(0, radix[0])), 16'd1);
        else if (r < 55)
          send_item(ACT_STEP, radix[0], 16'd1);
        else
          send_item(ACT_STEP, radix[0], 16'($urandom_range(0, radix[1])));
      end
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items over %0d register settings; %0d results compared",
             n_items, n_configs, n_results);
    $display("Rejections seen: %0d bad begin, %0d bad 2-D step, %0d digit overflow",
             n_bad_begin, n_bad_step, n_digit_ovf);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending_results);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
